/* hw/rtl/tpsc_pkg.sv */
// Package for the TS PID stream classifier: request codes, class codes,
// format identifiers and the controller/datapath handshake structs.
// No dependencies.
package tpsc_pkg;

   // table size default
   localparam int TPSC_TABLE_DEPTH = 32;

   // request codes
   localparam logic [2:0] REQ_TABLE_START = 3'd0;
   localparam logic [2:0] REQ_ENTRY_START = 3'd1;
   localparam logic [2:0] REQ_DESCRIPTOR  = 3'd2;
   localparam logic [2:0] REQ_ENTRY_END   = 3'd3;
   localparam logic [2:0] REQ_PID_QUERY   = 3'd4;

   // stream class codes
   localparam logic [3:0] CLS_UNKNOWN = 4'd0;
   localparam logic [3:0] CLS_KLVA    = 4'd1;
   localparam logic [3:0] CLS_EXI     = 4'd2;
   localparam logic [3:0] CLS_XML     = 4'd3;
   localparam logic [3:0] CLS_HDMV    = 4'd4;
   localparam logic [3:0] CLS_H264    = 4'd5;
   localparam logic [3:0] CLS_VIDEO   = 4'd6;
   localparam logic [3:0] CLS_AUDIO   = 4'd7;
   localparam logic [3:0] CLS_H265    = 4'd8;

   // stream type bytes
   localparam logic [7:0] ST_VIDEO_MPEG2 = 8'h02;
   localparam logic [7:0] ST_AUDIO_A     = 8'h03;
   localparam logic [7:0] ST_AUDIO_B     = 8'h04;
   localparam logic [7:0] ST_PRIVATE     = 8'h06;
   localparam logic [7:0] ST_METADATA    = 8'h15;
   localparam logic [7:0] ST_H264        = 8'h1B;
   localparam logic [7:0] ST_H265        = 8'h24;

   // descriptor tags
   localparam logic [7:0] TAG_REGISTRATION = 8'h05;
   localparam logic [7:0] TAG_METADATA     = 8'h26;

   // format identifiers and fixed HDMV tags
   localparam logic [31:0] ID_KLVA = 32'h4B4C5641;
   localparam logic [31:0] ID_EXI  = 32'h24455849;
   localparam logic [31:0] ID_XML  = 32'h24584D4C;
   localparam logic [31:0] ID_HEVC = 32'h48455643;
   localparam logic [63:0] HDMV_TAG_A = 64'h48444D56FF1B443F;
   localparam logic [63:0] HDMV_TAG_B = 64'h48445052FF1B673F;

   // controller to datapath commands
   typedef struct packed {
      logic accept;       // input transfer this cycle
      logic scan_step;    // advance table scan
      logic scan_finish;  // scan ends, post result
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic needs_scan;   // offered item needs a table scan
      logic scan_done;    // scan has its answer
   } dp_status_type;

endpackage

/* hw/rtl/tpsc_ctrl.sv */
// Controller for the TS PID stream classifier: idle/scan state machine.
// Depends on tpsc_pkg.
module tpsc_ctrl
   import tpsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.accept      = 1'b0;
      cmd.scan_step   = 1'b0;
      cmd.scan_finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start && status.needs_scan) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/tpsc_dpath.sv */
// Datapath for the TS PID stream classifier: entry state, descriptor
// decode, PID table memory with serial scan, and result registers.
// Depends on tpsc_pkg.
module tpsc_dpath
   import tpsc_pkg::*;
#(
   parameter int TABLE_DEPTH = TPSC_TABLE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [2:0]    req_type,
   input  logic [4:0]    req_version,
   input  logic [12:0]   req_pid,
   input  logic [7:0]    req_stream_type_code,
   input  logic [7:0]    req_desc_tag,
   input  logic [7:0]    req_desc_len,
   input  logic [63:0]   req_desc_bytes,
   input  logic [7:0]    req_desc_byte_nine,
   output logic          rsp_strobe,
   output logic [3:0]    rsp_stream_class,
   output logic          rsp_hit,
   output logic          rsp_table_full,
   output logic          rsp_skipped
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [12:0] pid;
      logic [3:0]  cls;
   } slot_type;

   // format identifier to class
   function automatic logic [3:0] id_class(input logic [31:0] id);
      logic [3:0] c;
      c = CLS_UNKNOWN;
      if (id == ID_KLVA) begin
         c = CLS_KLVA;
      end else if (id == ID_EXI) begin
         c = CLS_EXI;
      end else if (id == ID_XML) begin
         c = CLS_XML;
      end
      return c;
   endfunction

   // entry and table state
   logic [5:0]    last_version_ff, last_version_in;
   logic          skip_table_ff, skip_table_in;
   logic [12:0]   entry_pid_ff, entry_pid_in;
   logic [7:0]    entry_type_ff, entry_type_in;
   logic          desc_found_ff, desc_found_in;
   logic [3:0]    captured_ff, captured_in;
   logic [CW-1:0] fill_ff, fill_in;

   // scan state
   logic [CW-1:0] idx_ff, idx_in;
   logic [12:0]   key_ff, key_in;
   logic          op_ins_ff, op_ins_in;
   slot_type      rd_ff;
   slot_type      slot_mem [TABLE_DEPTH];

   // result registers
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]    rsp_class_ff, rsp_class_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_full_ff, rsp_full_in;
   logic          rsp_skip_ff, rsp_skip_in;

   // descriptor payload with bytes beyond length zeroed
   logic [63:0]   pay;
   logic [7:0]    pay_nine;
   logic [3:0]    desc_class;
   logic          desc_decides;

   logic          match;
   logic          table_has_room;
   logic          wr_en;
   logic          rd_en;
   logic          in_skipped;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         pay[63 - 8 * j -: 8] = (req_desc_len > 8'(j)) ? req_desc_bytes[63 - 8 * j -: 8] : 8'h00;
      end
      pay_nine = (req_desc_len >= 8'd9) ? req_desc_byte_nine : 8'h00;
   end

   // first deciding descriptor of the entry
   always_comb begin
      desc_decides = 1'b0;
      desc_class   = CLS_UNKNOWN;
      case (entry_type_ff)
         ST_PRIVATE, ST_METADATA: begin
            if (req_desc_tag == TAG_REGISTRATION) begin
               desc_decides = 1'b1;
               desc_class   = id_class(pay[63:32]);
            end else if (req_desc_tag == TAG_METADATA) begin
               desc_decides = 1'b1;
               desc_class   = id_class(pay[39:8]);
            end
         end
         ST_H264: begin
            if (req_desc_tag == TAG_REGISTRATION) begin
               desc_decides = 1'b1;
               desc_class   = ((pay == HDMV_TAG_A || pay == HDMV_TAG_B) && pay_nine == 8'h00)
                              ? CLS_HDMV : CLS_H264;
            end
         end
         ST_H265: begin
            if (req_desc_tag == TAG_REGISTRATION) begin
               desc_decides = 1'b1;
               desc_class   = (pay[63:32] == ID_HEVC) ? CLS_H265 : CLS_UNKNOWN;
            end
         end
         default: begin
            desc_decides = 1'b0;
         end
      endcase
   end

   // scan compare: idx points one past the entry held in rd_ff
   assign match          = (idx_ff != '0) && (rd_ff.pid == key_ff);
   assign table_has_room = (fill_ff < CW'(TABLE_DEPTH));
   assign rd_en          = cmd.scan_step && (idx_ff < fill_ff);
   assign wr_en          = cmd.scan_finish && op_ins_ff && !match && table_has_room;

   assign in_skipped = skip_table_ff && (req_type == REQ_ENTRY_START ||
                       req_type == REQ_DESCRIPTOR || req_type == REQ_ENTRY_END);

   assign status.needs_scan = (req_type == REQ_PID_QUERY) ||
                              (req_type == REQ_ENTRY_END && !skip_table_ff &&
                               captured_ff != CLS_UNKNOWN);
   assign status.scan_done  = match || (idx_ff >= fill_ff);

   // next state and result
   always_comb begin
      last_version_in = last_version_ff;
      skip_table_in   = skip_table_ff;
      entry_pid_in    = entry_pid_ff;
      entry_type_in   = entry_type_ff;
      desc_found_in   = desc_found_ff;
      captured_in     = captured_ff;
      fill_in         = fill_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      op_ins_in       = op_ins_ff;
      rsp_strobe_in   = 1'b0;
      rsp_class_in    = rsp_class_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_skip_in     = rsp_skip_ff;

      if (cmd.accept) begin
         idx_in        = '0;
         key_in        = (req_type == REQ_PID_QUERY) ? req_pid : entry_pid_ff;
         op_ins_in     = (req_type != REQ_PID_QUERY);
         rsp_strobe_in = !status.needs_scan;
         rsp_class_in  = CLS_UNKNOWN;
         rsp_hit_in    = 1'b0;
         rsp_full_in   = 1'b0;
         rsp_skip_in   = 1'b0;
         if (req_type == REQ_TABLE_START) begin
            if ({1'b0, req_version} == last_version_ff) begin
               skip_table_in = 1'b1;
               rsp_skip_in   = 1'b1;
            end else begin
               last_version_in = {1'b0, req_version};
               skip_table_in   = 1'b0;
            end
         end else if (in_skipped) begin
            rsp_skip_in = 1'b1;
         end else if (req_type == REQ_ENTRY_START) begin
            entry_pid_in  = req_pid;
            entry_type_in = req_stream_type_code;
            desc_found_in = 1'b0;
            if (req_stream_type_code == ST_H264) begin
               captured_in = CLS_H264;
            end else if (req_stream_type_code == ST_VIDEO_MPEG2) begin
               captured_in = CLS_VIDEO;
            end else if (req_stream_type_code == ST_AUDIO_A ||
                         req_stream_type_code == ST_AUDIO_B) begin
               captured_in = CLS_AUDIO;
            end else begin
               captured_in = CLS_UNKNOWN;
            end
            rsp_class_in = captured_in;
         end else if (req_type == REQ_DESCRIPTOR) begin
            if (!desc_found_ff && desc_decides) begin
               desc_found_in = 1'b1;
               captured_in   = desc_class;
            end
            rsp_class_in = captured_in;
         end else if (req_type == REQ_ENTRY_END) begin
            // unknown class: no insert, answered at once
            rsp_class_in = captured_ff;
         end
      end

      if (cmd.scan_step) begin
         idx_in = idx_ff + CW'(1);
      end

      // scan result
      if (cmd.scan_finish) begin
         rsp_strobe_in = 1'b1;
         rsp_skip_in   = 1'b0;
         if (op_ins_ff) begin
            rsp_class_in = captured_ff;
            rsp_hit_in   = !match && table_has_room;
            rsp_full_in  = !match && !table_has_room;
            if (wr_en) begin
               fill_in = fill_ff + CW'(1);
            end
         end else begin
            rsp_class_in = match ? rd_ff.cls : CLS_UNKNOWN;
            rsp_hit_in   = match;
            rsp_full_in  = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_version_ff <= 6'd32;
         skip_table_ff   <= 1'b0;
         entry_pid_ff    <= '0;
         entry_type_ff   <= '0;
         desc_found_ff   <= 1'b0;
         captured_ff     <= CLS_UNKNOWN;
         fill_ff         <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         last_version_ff <= last_version_in;
         skip_table_ff   <= skip_table_in;
         entry_pid_ff    <= entry_pid_in;
         entry_type_ff   <= entry_type_in;
         desc_found_ff   <= desc_found_in;
         captured_ff     <= captured_in;
         fill_ff         <= fill_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      op_ins_ff    <= op_ins_in;
      rsp_class_ff <= rsp_class_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_skip_ff  <= rsp_skip_in;
   end

   // slot memory: written at fill count, read at scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[fill_ff[AW-1:0]] <= '{pid: entry_pid_ff, cls: captured_ff};
      end
      if (rd_en) begin
         rd_ff <= slot_mem[idx_ff[AW-1:0]];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_stream_class = rsp_class_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_skipped      = rsp_skip_ff;

endmodule

/* hw/rtl/ts_pid_stream_classifier.sv */
// Top level of the TS PID stream classifier: controller plus datapath.
// Depends on tpsc_pkg, tpsc_ctrl, tpsc_dpath.
//
//   channel   | ports                               | transfer
//   ----------+-------------------------------------+---------------------------
//   request   | start, busy, req_*                  | start high, busy low
//   response  | rsp_strobe, rsp_*                   | rsp_strobe high, one cycle
//
// Table start, entry start, descriptor, skipped or unknown-class entry end and
// unused codes respond in the cycle after the transfer; busy stays low.
// PID query and entry end walk the slot memory one entry a cycle (one read port):
// busy until the walk ends on a PID match or past the last filled slot, and the
// response is shown as busy falls.
// Synchronous active-high reset empties the table; no clearing pass.
// The receiver cannot stall: each response is shown for exactly one cycle.
module ts_pid_stream_classifier
   import tpsc_pkg::*;
#(
   parameter int TABLE_DEPTH = TPSC_TABLE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_version,
   input  logic [12:0] req_pid,
   input  logic [7:0]  req_stream_type_code,
   input  logic [7:0]  req_desc_tag,
   input  logic [7:0]  req_desc_len,
   input  logic [63:0] req_desc_bytes,
   input  logic [7:0]  req_desc_byte_nine,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_stream_class,
   output logic        rsp_hit,
   output logic        rsp_table_full,
   output logic        rsp_skipped
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tpsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tpsc_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_type             (req_type),
      .req_version          (req_version),
      .req_pid              (req_pid),
      .req_stream_type_code (req_stream_type_code),
      .req_desc_tag         (req_desc_tag),
      .req_desc_len         (req_desc_len),
      .req_desc_bytes       (req_desc_bytes),
      .req_desc_byte_nine   (req_desc_byte_nine),
      .rsp_strobe           (rsp_strobe),
      .rsp_stream_class     (rsp_stream_class),
      .rsp_hit              (rsp_hit),
      .rsp_table_full       (rsp_table_full),
      .rsp_skipped          (rsp_skipped)
   );

endmodule

/* hw/rtl/tpsc_checker.sv */
// Port-level checker for the TS PID stream classifier, bound to the top level.
// Depends on tpsc_pkg and ts_pid_stream_classifier.
module tpsc_checker
   import tpsc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_type,
   input logic       rsp_strobe,
   input logic [3:0] rsp_stream_class,
   input logic       rsp_hit,
   input logic       rsp_table_full,
   input logic       rsp_skipped
);

   // items without a table lookup answer in the next cycle
   a_short_items: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_TABLE_START || req_type == REQ_ENTRY_START ||
       req_type == REQ_DESCRIPTOR || req_type > REQ_PID_QUERY)) |=> (rsp_strobe && !busy))
      else $error("short item did not answer next cycle");

   // a lookup start carries no response
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      ($rose(busy) && !$past(reset)) |-> !rsp_strobe)
      else $error("response while lookup starts");

   // lookup end always posts a response
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("lookup ended without response");

   // skipped items carry nothing else
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_skipped) |-> (rsp_stream_class == CLS_UNKNOWN && !rsp_hit &&
                                       !rsp_table_full))
      else $error("skipped response carries data");

   // a dropped insert never also reports a new entry
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_table_full))
      else $error("hit and table_full together");

endmodule

bind ts_pid_stream_classifier tpsc_checker u_tpsc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_type         (req_type),
   .rsp_strobe       (rsp_strobe),
   .rsp_stream_class (rsp_stream_class),
   .rsp_hit          (rsp_hit),
   .rsp_table_full   (rsp_table_full),
   .rsp_skipped      (rsp_skipped)
);
